// ===== rtl/core/mrta_pkg.sv =====
// ----------------------------------------------------------------------------
// mrta_pkg
// Shared codes, widths and control/status types of the rule table automaton.
// ----------------------------------------------------------------------------
package mrta_pkg;

	localparam int CNT_W      = 13;
	localparam int RULE_WORDS = 8;
	localparam int RULE_W     = 64;
	localparam int RIDX_W     = 3;
	localparam int CMD_W      = 2;
	localparam int COORD_W    = 6;
	localparam int SIDE_W     = 7;
	localparam int IDX_W      = 9;

	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RULE    = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_BOARD_SIDE = 1'b0;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

	typedef struct packed {
		logic latch_in;
		logic cell_rd;
		logic cell_fin;
		logic rule_fin;
		logic clr_start;
		logic clr_wr;
		logic adv_start;
		logic fetch;
		logic shift;
		logic sweep;
		logic row_wr;
		logic adv_fin;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic clr_last;
		logic col_last;
		logic row_last;
	} dp_stat_t;

endpackage

// ===== rtl/core/moore_rule_table_automaton.sv =====
// ----------------------------------------------------------------------------
// moore_rule_table_automaton
// Square binary board with a 3x3 neighbourhood and a 512-entry rule table.
//
//   channel  handshake                      payload
//   item     item_valid / item_stall        command, row_index, column_index,
//                                           cell_value, rule_word_index,
//                                           rule_word_data
//   result   result_valid / result_stall    read_value, live_count
//   config   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Cell write and cell read first read the row from the board memory, then
// do the read-modify-write (for a write) and load the result register; a rule
// load writes its word and loads the result register. An advance does one rule
// lookup per cell, plus a row fetch, a window shift and a row write per row.
// After reset and after each board_side write a clearing pass wipes every
// row of both banks; items are stalled meanwhile.
// A stalled result holds; the next beat is taken while it waits.
// ----------------------------------------------------------------------------
module moore_rule_table_automaton #(
	parameter int MAX_SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [mrta_pkg::CMD_W-1:0]    command,
	input  logic [mrta_pkg::COORD_W-1:0]  row_index,
	input  logic [mrta_pkg::COORD_W-1:0]  column_index,
	input  logic                          cell_value,
	input  logic [mrta_pkg::RIDX_W-1:0]   rule_word_index,
	input  logic [mrta_pkg::RULE_W-1:0]   rule_word_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          read_value,
	output logic [mrta_pkg::CNT_W-1:0]    live_count,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [mrta_pkg::SIDE_W-1:0] board_side_q;
	logic                        cfg_wr;
	mrta_pkg::dp_cmd_t           dp_cmd;
	mrta_pkg::dp_stat_t          dp_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == mrta_pkg::REG_BOARD_SIDE);
	assign prdata = (paddr[2] == mrta_pkg::REG_BOARD_SIDE)
		? {25'd0, board_side_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_side_q <= mrta_pkg::SIDE_RESET;
		end else if (cfg_wr) begin
			board_side_q <= pwdata[mrta_pkg::SIDE_W-1:0];
		end
	end

	mrta_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.command    (command),
		.cfg_wr     (cfg_wr),
		.stat       (dp_stat),
		.item_stall (item_stall),
		.ctl        (dp_cmd)
	);

	mrta_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (dp_cmd),
		.stat            (dp_stat),
		.board_side      (board_side_q),
		.command         (command),
		.row_index       (row_index),
		.column_index    (column_index),
		.cell_value      (cell_value),
		.rule_word_index (rule_word_index),
		.rule_word_data  (rule_word_data),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.read_value      (read_value),
		.live_count      (live_count)
	);

	// a taken beat keeps the block busy for at least the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item taken twice in a row");

	// a side write starts the clearing pass
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> item_stall)
		else $error("items not stalled after side write");

	// a result is loaded only into a free output slot
	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.cell_fin || dp_cmd.rule_fin || dp_cmd.adv_fin) |-> dp_stat.slot_free)
		else $error("result overwrote a waiting beat");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.cell_fin, dp_cmd.rule_fin, dp_cmd.adv_fin}))
		else $error("more than one result in a cycle");

endmodule

// ===== rtl/core/mrta_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrta_ctrl
// Sequencer: clearing pass, command dispatch and the row/cell walk of an advance.
// ----------------------------------------------------------------------------
module mrta_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic [mrta_pkg::CMD_W-1:0]  command,
	input  logic                        cfg_wr,
	input  mrta_pkg::dp_stat_t          stat,
	output logic                        item_stall,
	output mrta_pkg::dp_cmd_t           ctl
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_CELL    = 4'd2;
	localparam logic [3:0] ST_RULE    = 4'd3;
	localparam logic [3:0] ST_PRIME_F = 4'd4;
	localparam logic [3:0] ST_PRIME_S = 4'd5;
	localparam logic [3:0] ST_FETCH   = 4'd6;
	localparam logic [3:0] ST_SHIFT   = 4'd7;
	localparam logic [3:0] ST_SWEEP   = 4'd8;
	localparam logic [3:0] ST_ROWWR   = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign item_stall = (state_q != ST_IDLE) || cfg_wr;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					ctl.latch_in = 1'b1;
					unique case (command) inside
						mrta_pkg::CMD_WRITE, mrta_pkg::CMD_READ: begin
							ctl.cell_rd = 1'b1;
							state_d     = ST_CELL;
						end
						mrta_pkg::CMD_ADVANCE: begin
							ctl.adv_start = 1'b1;
							state_d       = ST_PRIME_F;
						end
						default: begin
							state_d = ST_RULE;
						end
					endcase
				end
			end
			ST_CELL: begin
				if (stat.slot_free) begin
					ctl.cell_fin = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RULE: begin
				if (stat.slot_free) begin
					ctl.rule_fin = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_PRIME_F: begin
				ctl.fetch = 1'b1;
				state_d   = ST_PRIME_S;
			end
			ST_PRIME_S: begin
				ctl.shift = 1'b1;
				state_d   = ST_FETCH;
			end
			ST_FETCH: begin
				ctl.fetch = 1'b1;
				state_d   = ST_SHIFT;
			end
			ST_SHIFT: begin
				ctl.shift = 1'b1;
				state_d   = ST_SWEEP;
			end
			ST_SWEEP: begin
				ctl.sweep = 1'b1;
				if (stat.col_last) begin
					state_d = ST_ROWWR;
				end
			end
			ST_ROWWR: begin
				ctl.row_wr = 1'b1;
				state_d    = stat.row_last ? ST_DONE : ST_FETCH;
			end
			ST_DONE: begin
				if (stat.slot_free) begin
					ctl.adv_fin = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		// new side: wipe both banks again
		if (cfg_wr) begin
			ctl.clr_start = 1'b1;
			state_d       = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/mrta_datapath.sv =====
// ----------------------------------------------------------------------------
// mrta_datapath
// Row-wide board memory, row window, rule table lookup, live count and result.
// ----------------------------------------------------------------------------
module mrta_datapath #(
	parameter int MAX_SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mrta_pkg::dp_cmd_t             ctl,
	output mrta_pkg::dp_stat_t            stat,
	input  logic [mrta_pkg::SIDE_W-1:0]   board_side,
	input  logic [mrta_pkg::CMD_W-1:0]    command,
	input  logic [mrta_pkg::COORD_W-1:0]  row_index,
	input  logic [mrta_pkg::COORD_W-1:0]  column_index,
	input  logic                          cell_value,
	input  logic [mrta_pkg::RIDX_W-1:0]   rule_word_index,
	input  logic [mrta_pkg::RULE_W-1:0]   rule_word_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          read_value,
	output logic [mrta_pkg::CNT_W-1:0]    live_count
);

	localparam int RW       = $clog2(MAX_SIDE);
	localparam int SW       = $clog2(MAX_SIDE + 1);
	localparam int AW       = RW + 1;
	localparam int PW       = $clog2(MAX_SIDE + 2);
	localparam int MEM_ROWS = 2 ** AW;
	localparam int CW       = mrta_pkg::CNT_W;

	localparam logic [8:0] MAX9 = 9'(MAX_SIDE);

	// board: one row per entry, bank in the top address bit
	logic [MAX_SIDE-1:0] board_mem [MEM_ROWS];
	logic [MAX_SIDE-1:0] rd_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [MAX_SIDE-1:0] wr_data;

	logic [mrta_pkg::RULE_W-1:0] rule_q [mrta_pkg::RULE_WORDS];

	logic [mrta_pkg::CMD_W-1:0]   op_q;
	logic [mrta_pkg::COORD_W-1:0] row_q;
	logic [mrta_pkg::COORD_W-1:0] col_q;
	logic                         val_q;
	logic [mrta_pkg::RIDX_W-1:0]  widx_q;
	logic [mrta_pkg::RULE_W-1:0]  wdata_q;

	logic          bank_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] alive_q;
	logic [CW-1:0] alive_d;
	logic [CW-1:0] adv_cnt_q;
	logic [RW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [SW-1:0] fptr_q;

	logic [MAX_SIDE-1:0] up_q;
	logic [MAX_SIDE-1:0] mid_q;
	logic [MAX_SIDE-1:0] dn_q;
	logic [MAX_SIDE-1:0] new_row_q;

	logic          out_valid_q;
	logic          read_value_q;
	logic [CW-1:0] live_count_q;

	logic [8:0]          side9;
	logic [8:0]          side_c9;
	logic [SW-1:0]       side_eff;
	logic                in_rng;
	logic [RW-1:0]       row_ix;
	logic [RW-1:0]       col_ix;
	logic                cell_now;
	logic                changed;
	logic                rv;
	logic                produce;
	logic                fvalid;
	logic [PW-1:0]       pc0;
	logic [PW-1:0]       pc1;
	logic [PW-1:0]       pc2;
	logic                right_ok;
	logic [MAX_SIDE+1:0] ext_up;
	logic [MAX_SIDE+1:0] ext_mid;
	logic [MAX_SIDE+1:0] ext_dn;
	logic [mrta_pkg::IDX_W-1:0] nb_idx;
	logic                rbit;
	logic [MAX_SIDE-1:0] patched;

	// side 0 acts as 1, anything above the maximum as the maximum
	assign side9    = 9'(board_side);
	assign side_c9  = (side9 == 9'd0) ? 9'd1 : ((side9 > MAX9) ? MAX9 : side9);
	assign side_eff = SW'(side_c9);

	assign in_rng   = (10'(row_q) < 10'(side_eff)) && (10'(col_q) < 10'(side_eff));
	assign row_ix   = RW'(row_q);
	assign col_ix   = RW'(col_q);
	assign cell_now = in_rng & rd_q[col_ix];
	assign changed  = in_rng && (rd_q[col_ix] != val_q);

	always_comb begin
		patched         = rd_q;
		patched[col_ix] = val_q;
	end

	// neighbourhood window, padded so the left edge reads zero
	assign ext_up   = {1'b0, up_q, 1'b0};
	assign ext_mid  = {1'b0, mid_q, 1'b0};
	assign ext_dn   = {1'b0, dn_q, 1'b0};
	assign pc0      = PW'(c_q);
	assign pc1      = pc0 + PW'(1);
	assign pc2      = pc0 + PW'(2);
	assign right_ok = ((SW+1)'(c_q) + (SW+1)'(1)) < (SW+1)'(side_eff);
	assign nb_idx   = {ext_up[pc0], ext_up[pc1], ext_up[pc2] & right_ok,
		ext_mid[pc0], ext_mid[pc1], ext_mid[pc2] & right_ok,
		ext_dn[pc0], ext_dn[pc1], ext_dn[pc2] & right_ok};
	assign rbit     = rule_q[nb_idx[8:6]][nb_idx[5:0]];

	assign fvalid = fptr_q < side_eff;

	assign stat.slot_free = !out_valid_q || !result_stall;
	assign stat.clr_last  = (clr_q == '1);
	assign stat.col_last  = ((SW+1)'(c_q) + (SW+1)'(1)) == (SW+1)'(side_eff);
	assign stat.row_last  = ((SW+1)'(r_q) + (SW+1)'(1)) == (SW+1)'(side_eff);

	assign produce = ctl.cell_fin || ctl.rule_fin || ctl.adv_fin;

	always_comb begin
		alive_d = alive_q;
		rv      = 1'b0;
		if (ctl.cell_fin) begin
			if (op_q == mrta_pkg::CMD_READ) begin
				rv = cell_now;
			end else if (changed) begin
				alive_d = val_q ? (alive_q + CW'(1)) : (alive_q - CW'(1));
			end
		end
		if (ctl.adv_fin) begin
			alive_d = adv_cnt_q;
		end
		if (ctl.clr_start) begin
			alive_d = '0;
		end
	end

	// memory ports
	assign rd_en   = ctl.cell_rd || ctl.fetch;
	assign rd_addr = ctl.cell_rd ? {bank_q, RW'(row_index)} : {bank_q, fptr_q[RW-1:0]};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (ctl.clr_wr) begin
			wr_en = 1'b1;
		end else if (ctl.cell_fin && (op_q == mrta_pkg::CMD_WRITE) && changed) begin
			wr_en   = 1'b1;
			wr_addr = {bank_q, row_ix};
			wr_data = patched;
		end else if (ctl.row_wr) begin
			wr_en   = 1'b1;
			wr_addr = {~bank_q, r_q};
			wr_data = new_row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			board_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= board_mem[rd_addr];
		end
	end

	// latched item
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			op_q    <= command;
			row_q   <= row_index;
			col_q   <= column_index;
			val_q   <= cell_value;
			widx_q  <= rule_word_index;
			wdata_q <= rule_word_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= '{default: '0};
		end else if (ctl.rule_fin) begin
			rule_q[widx_q] <= wdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= 1'b0;
			clr_q     <= '0;
			alive_q   <= '0;
			adv_cnt_q <= '0;
			c_q       <= '0;
			r_q       <= '0;
			fptr_q    <= '0;
		end else begin
			alive_q <= alive_d;
			if (ctl.clr_start) begin
				clr_q <= '0;
			end else if (ctl.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctl.adv_start) begin
				adv_cnt_q <= '0;
				r_q       <= '0;
				fptr_q    <= '0;
			end
			if (ctl.shift) begin
				fptr_q <= fptr_q + SW'(1);
				c_q    <= '0;
			end
			if (ctl.sweep) begin
				c_q       <= c_q + RW'(1);
				adv_cnt_q <= adv_cnt_q + CW'(rbit);
			end
			if (ctl.row_wr) begin
				r_q <= r_q + RW'(1);
			end
			if (ctl.adv_fin) begin
				bank_q <= ~bank_q;
			end
		end
	end

	// row window and the row being built
	always_ff @(posedge clk) begin
		if (ctl.adv_start) begin
			up_q  <= '0;
			mid_q <= '0;
			dn_q  <= '0;
		end else if (ctl.shift) begin
			up_q  <= mid_q;
			mid_q <= dn_q;
			dn_q  <= fvalid ? rd_q : '0;
		end
		if (ctl.shift) begin
			new_row_q <= '0;
		end else if (ctl.sweep) begin
			new_row_q[c_q] <= rbit;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			read_value_q <= rv;
			live_count_q <= alive_d;
		end
	end

	assign result_valid = out_valid_q;
	assign read_value   = read_value_q;
	assign live_count   = live_count_q;

endmodule

// ===== dv/automaton_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// automaton_checker
// Watches the item, result and config channels of the rule table automaton,
// keeps its own copy of the board, rule table and live count, and compares
// every result beat with the oldest expected report.
// ----------------------------------------------------------------------------
module automaton_checker #(
	parameter int MAX_SIDE = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  logic [mrta_pkg::CMD_W-1:0]     command,
	input  logic [mrta_pkg::COORD_W-1:0]   row_index,
	input  logic [mrta_pkg::COORD_W-1:0]   column_index,
	input  logic                           cell_value,
	input  logic [mrta_pkg::RIDX_W-1:0]    rule_word_index,
	input  logic [mrta_pkg::RULE_W-1:0]    rule_word_data,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic                           read_value,
	input  logic [mrta_pkg::CNT_W-1:0]     live_count,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	output int                             outstanding,
	output int                             errors
);

	typedef struct packed {
		logic                       alive;
		logic [mrta_pkg::CNT_W-1:0] population;
	} report_t;

	bit                          cells [2][MAX_SIDE][MAX_SIDE];
	bit                          shown;
	logic [mrta_pkg::RULE_W-1:0] rules [mrta_pkg::RULE_WORDS];
	logic [mrta_pkg::CNT_W-1:0]  population;
	logic [mrta_pkg::SIDE_W-1:0] side_reg;
	report_t                     due_reports [$];
	int                          bad = 0;
	int                          beats = 0;

	assign errors = bad;

	function automatic int live_side();
		if (side_reg == 0) return 1;
		if (side_reg > MAX_SIDE) return MAX_SIDE;
		return side_reg;
	endfunction

	function automatic bit cell_of(bit bank, int r, int c, int s);
		if (r < 0 || c < 0 || r >= s || c >= s) return 1'b0;
		return cells[bank][r][c];
	endfunction

	function automatic void wipe_board();
		for (int b = 0; b < 2; b++)
			for (int r = 0; r < MAX_SIDE; r++)
				for (int c = 0; c < MAX_SIDE; c++)
					cells[b][r][c] = 1'b0;
		population = '0;
	endfunction

	function automatic void next_generation();
		int                         s;
		int                         pos;
		bit                         src;
		logic [mrta_pkg::IDX_W-1:0] hood;
		logic [mrta_pkg::CNT_W-1:0] total;
		s = live_side();
		src = shown;
		total = '0;
		for (int r = 0; r < MAX_SIDE; r++)
			for (int c = 0; c < MAX_SIDE; c++)
				cells[!src][r][c] = 1'b0;
		for (int r = 0; r < s; r++) begin
			for (int c = 0; c < s; c++) begin
				// top-left neighbour lands in the top bit, off-board ones read as dead
				pos = mrta_pkg::IDX_W - 1;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						hood[pos] = cell_of(src, r + dr, c + dc, s);
						pos--;
					end
				end
				cells[!src][r][c] = rules[hood[8:6]][hood[5:0]];
				total += cells[!src][r][c];
			end
		end
		shown = !src;
		population = total;
	endfunction

	function automatic report_t command_outcome(
		input logic [mrta_pkg::CMD_W-1:0]   cmd,
		input logic [mrta_pkg::COORD_W-1:0] row,
		input logic [mrta_pkg::COORD_W-1:0] col,
		input logic                         val,
		input logic [mrta_pkg::RIDX_W-1:0]  widx,
		input logic [mrta_pkg::RULE_W-1:0]  wdata
	);
		report_t rep;
		int      s;
		s = live_side();
		rep.alive = 1'b0;
		case (cmd)
			mrta_pkg::CMD_WRITE: begin
				// count moves only on a real change of the cell
				if (row < s && col < s && cells[shown][row][col] != val) begin
					cells[shown][row][col] = val;
					if (val) population++;
					else population--;
				end
			end
			mrta_pkg::CMD_READ:    rep.alive = cell_of(shown, row, col, s);
			mrta_pkg::CMD_ADVANCE: next_generation();
			mrta_pkg::CMD_RULE:    rules[widx] = wdata;
		endcase
		rep.population = population;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			wipe_board();
			for (int w = 0; w < mrta_pkg::RULE_WORDS; w++) rules[w] = '0;
			shown = 1'b0;
			side_reg = mrta_pkg::SIDE_RESET;
			due_reports.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_reports.size() == 0) begin
					if (bad < 10)
						$display("%0t: result beat %0d with nothing expected, read %0b count %0d",
							$time, beats, read_value, live_count);
					bad++;
				end else begin
					want = due_reports.pop_front();
					if (read_value !== want.alive || live_count !== want.population) begin
						if (bad < 10)
							$display("%0t: result beat %0d read exp %0b got %0b, count exp %0d got %0d",
								$time, beats, want.alive, read_value, want.population, live_count);
						bad++;
					end
				end
				beats++;
			end
			if (psel && penable && pwrite && pready
				&& paddr[2] == mrta_pkg::REG_BOARD_SIDE) begin
				// a new side rebuilds the board, rules survive
				side_reg = pwdata[mrta_pkg::SIDE_W-1:0];
				wipe_board();
			end
			if (item_valid && !item_stall)
				due_reports.push_back(command_outcome(command, row_index, column_index,
					cell_value, rule_word_index, rule_word_data));
			outstanding <= due_reports.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives cell writes, reads, rule loads and generation steps into the rule
// table automaton over a range of board sides, with random idling on both
// channels and one long result hold-off; the checker scores every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_SIDE = 64;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          item_valid = 1'b0;
	logic                          item_stall;
	logic [mrta_pkg::CMD_W-1:0]    command = mrta_pkg::CMD_READ;
	logic [mrta_pkg::COORD_W-1:0]  row_index = '0;
	logic [mrta_pkg::COORD_W-1:0]  column_index = '0;
	logic                          cell_value = 1'b0;
	logic [mrta_pkg::RIDX_W-1:0]   rule_word_index = '0;
	logic [mrta_pkg::RULE_W-1:0]   rule_word_data = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic                          read_value;
	logic [mrta_pkg::CNT_W-1:0]    live_count;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [2:0]                    paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	int outstanding;
	int errors;
	int sent = 0;
	bit calm = 1'b0;
	bit hold_off = 1'b0;

	moore_rule_table_automaton #(.MAX_SIDE(MAX_SIDE)) dut (.*);

	automaton_checker #(.MAX_SIDE(MAX_SIDE)) u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic offer_item(
		input logic [mrta_pkg::CMD_W-1:0]   cmd,
		input logic [mrta_pkg::COORD_W-1:0] r,
		input logic [mrta_pkg::COORD_W-1:0] c,
		input logic                         v,
		input logic [mrta_pkg::RIDX_W-1:0]  wi,
		input logic [mrta_pkg::RULE_W-1:0]  wd
	);
		while (!calm && $urandom_range(99) < 23) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid      <= 1'b1;
		command         <= cmd;
		row_index       <= r;
		column_index    <= c;
		cell_value      <= v;
		rule_word_index <= wi;
		rule_word_data  <= wd;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic touch_cell(input logic [mrta_pkg::CMD_W-1:0] cmd, input int r,
		input int c, input logic v);
		offer_item(cmd, 6'(r), 6'(c), v, 3'($urandom), {$urandom, $urandom});
	endtask

	task automatic load_rule(input int wi, input logic [mrta_pkg::RULE_W-1:0] wd);
		offer_item(mrta_pkg::CMD_RULE, 6'($urandom), 6'($urandom), 1'($urandom), 3'(wi), wd);
	endtask

	task automatic step_board();
		offer_item(mrta_pkg::CMD_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom),
			3'($urandom), {$urandom, $urandom});
	endtask

	// drop valid and wait for every expected report to drain
	task automatic settle(input int tail);
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic set_side(input logic [mrta_pkg::SIDE_W-1:0] v);
		settle(8);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {mrta_pkg::REG_BOARD_SIDE, 2'b00};
		pwdata  <= {25'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [mrta_pkg::RULE_W-1:0] shaped_rule();
		logic [mrta_pkg::RULE_W-1:0] a;
		logic [mrta_pkg::RULE_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(4))
			0:       return a & b;
			1:       return a | b;
			2:       return $urandom_range(1) ? '0 : '1;
			default: return a;
		endcase
	endfunction

	// mostly on the board, now and then one step past its edge, clipped to 63
	function automatic int near_coord(input int span);
		int v;
		v = $urandom_range(span);
		return v > 63 ? 63 : v;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			result_stall <= !calm && ($urandom_range(99) < 23);
		end
	end

	initial begin
		#4_000_000;
		$display("moore_rule_table_automaton: mismatch");
		$finish;
	end

	initial begin
		logic [mrta_pkg::SIDE_W-1:0] raw;
		int                          eff;
		int                          k;
		int                          n;
		int                          adv_left;
		int                          phase;
		logic [mrta_pkg::CMD_W-1:0]  cmd;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// corners, no-change writes and a full-board step at the reset side
		touch_cell(mrta_pkg::CMD_READ, 0, 0, 1'b0);
		touch_cell(mrta_pkg::CMD_WRITE, 0, 0, 1'b1);
		touch_cell(mrta_pkg::CMD_WRITE, 63, 63, 1'b1);
		touch_cell(mrta_pkg::CMD_WRITE, 63, 63, 1'b1);
		touch_cell(mrta_pkg::CMD_WRITE, 63, 0, 1'b0);
		touch_cell(mrta_pkg::CMD_WRITE, 0, 63, 1'b1);
		touch_cell(mrta_pkg::CMD_READ, 63, 63, 1'b0);
		touch_cell(mrta_pkg::CMD_READ, 0, 63, 1'b0);
		touch_cell(mrta_pkg::CMD_WRITE, 0, 0, 1'b0);
		load_rule(0, '1);
		load_rule(7, 64'h8000_0000_0000_0000);
		step_board();
		touch_cell(mrta_pkg::CMD_READ, 32, 32, 1'b0);

		// tiny board: writes and reads past the side, edges read as dead
		set_side(7'd3);
		touch_cell(mrta_pkg::CMD_WRITE, 5, 5, 1'b1);
		touch_cell(mrta_pkg::CMD_READ, 5, 5, 1'b0);
		touch_cell(mrta_pkg::CMD_WRITE, 1, 1, 1'b1);
		touch_cell(mrta_pkg::CMD_WRITE, 0, 0, 1'b1);
		load_rule(2, {$urandom, $urandom});
		step_board();
		touch_cell(mrta_pkg::CMD_READ, 2, 2, 1'b0);

		// zero side behaves as one
		set_side(7'd0);
		touch_cell(mrta_pkg::CMD_WRITE, 0, 0, 1'b1);
		touch_cell(mrta_pkg::CMD_WRITE, 0, 1, 1'b1);
		step_board();
		touch_cell(mrta_pkg::CMD_READ, 0, 0, 1'b0);

		// oversize side clamps to the maximum
		set_side(7'd127);
		touch_cell(mrta_pkg::CMD_READ, 63, 63, 1'b0);

		phase = 0;
		while (sent < 1275) begin
			k = $urandom_range(99);
			if (k < 70) raw = 7'($urandom_range(10, 1));
			else if (k < 78) raw = 7'd0;
			else if (k < 84) raw = 7'($urandom_range(127, 65));
			else if (k < 90) raw = 7'd64;
			else raw = 7'($urandom_range(40, 11));
			set_side(raw);
			eff = (raw == 0) ? 1 : (raw > MAX_SIDE) ? MAX_SIDE : raw;
			// big boards are slow to step, keep those few
			adv_left = (eff > 16) ? 2 : 12;
			calm = (phase == 4);

			for (int w = 0; w < mrta_pkg::RULE_WORDS; w++) load_rule(w, shaped_rule());
			n = eff * eff / 3;
			if (n > 30) n = 30;
			if (n < 1) n = 1;
			repeat (n)
				touch_cell(mrta_pkg::CMD_WRITE, $urandom_range(eff - 1),
					$urandom_range(eff - 1), 1'b1);

			if (phase == 2) begin
				// back-to-back beats against a held-off receiver
				calm = 1'b1;
				hold_off = 1'b1;
				repeat (40)
					touch_cell($urandom_range(1) ? mrta_pkg::CMD_READ : mrta_pkg::CMD_WRITE,
						$urandom_range(eff - 1), $urandom_range(eff - 1), 1'($urandom));
				calm = 1'b0;
			end

			repeat (50) begin
				k = $urandom_range(99);
				if (k < 12) begin
					cmd = 2'($urandom);
					if (cmd == mrta_pkg::CMD_ADVANCE && adv_left == 0) cmd = mrta_pkg::CMD_READ;
					if (cmd == mrta_pkg::CMD_ADVANCE) adv_left--;
					offer_item(cmd, 6'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
						{$urandom, $urandom});
				end else if (k < 24 && adv_left > 0) begin
					step_board();
					adv_left--;
				end else if (k < 55) begin
					touch_cell(mrta_pkg::CMD_READ, near_coord(eff), near_coord(eff),
						1'($urandom));
				end else if (k < 85) begin
					touch_cell(mrta_pkg::CMD_WRITE, $urandom_range(eff - 1),
						$urandom_range(eff - 1), 1'($urandom));
				end else if (k < 92) begin
					load_rule($urandom_range(7), shaped_rule());
				end else begin
					touch_cell($urandom_range(1) ? mrta_pkg::CMD_READ : mrta_pkg::CMD_WRITE,
						$urandom_range(63), $urandom_range(63), 1'($urandom));
				end
			end
			calm = 1'b0;
			phase++;
		end

		settle(20);
		if (errors == 0 && outstanding == 0)
			$display("moore_rule_table_automaton: match");
		else
			$display("moore_rule_table_automaton: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mrta_pkg.sv
rtl/core/mrta_ctrl.sv
rtl/core/mrta_datapath.sv
rtl/core/moore_rule_table_automaton.sv
dv/automaton_checker.sv
dv/testbench.sv
